// ----- hw/rtl/csm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package csm_pkg;

   localparam int SAMPLE_W    = 8;
   localparam int CMD_W       = 2;
   localparam int SPAN_W      = SAMPLE_W + 1;
   localparam int DIV_STEPS   = SAMPLE_W;
   localparam int STEP_CNT_W  = $clog2(DIV_STEPS);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = '0;

   // command codes carried in the request tuser
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MEASURE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MAP     = 2'd2;

   // one map job, already classified by the front end
   typedef struct packed {
      logic                pass;        // nothing measured yet
      logic                full_scale;  // clamped sample sits on the maximum
      logic [SAMPLE_W-1:0] sample;
      logic [SAMPLE_W-1:0] low;
      logic [SAMPLE_W-1:0] high;
      logic [SPAN_W-1:0]   offset;      // clamped sample - low + 1
      logic [SPAN_W-1:0]   span;        // high - low + 1
   } map_entry_type;

   typedef struct packed {
      logic                   full;
      logic                   not_empty;
      logic [QUEUE_CNT_W-1:0] count;
   } queue_status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/csm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module csm_front
   import csm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [CMD_W-1:0]      req_command,
   input  wire logic [SAMPLE_W-1:0]   req_sample,
   input  wire queue_status_type      q_status,
   output logic                       q_push,
   output map_entry_type              q_entry
);

   logic [SAMPLE_W-1:0] min_ff, min_in;
   logic [SAMPLE_W-1:0] max_ff, max_in;
   logic [SAMPLE_W-1:0] clamped;
   logic                accept;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   // running bounds
   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (accept) begin
         unique case (req_command)
            CMD_CLEAR: begin
               min_in = SAMPLE_MAX;
               max_in = SAMPLE_MIN;
            end
            CMD_MEASURE: begin
               if (req_sample < min_ff) min_in = req_sample;
               if (req_sample > max_ff) max_in = req_sample;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= SAMPLE_MAX;
         max_ff <= SAMPLE_MIN;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   // classify a map job against the bounds as they stand now
   always_comb begin
      priority if (req_sample < min_ff) clamped = min_ff;
      else if (req_sample > max_ff)     clamped = max_ff;
      else                              clamped = req_sample;
   end

   always_comb begin
      q_push             = accept && (req_command == CMD_MAP);
      q_entry.pass       = min_ff > max_ff;
      q_entry.sample     = req_sample;
      q_entry.low        = min_ff;
      q_entry.high       = max_ff;
      q_entry.offset     = {1'b0, clamped} - {1'b0, min_ff} + SPAN_W'(1);
      q_entry.span       = {1'b0, max_ff} - {1'b0, min_ff} + SPAN_W'(1);
      q_entry.full_scale = clamped == max_ff;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/csm_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module csm_queue
   import csm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire map_entry_type    push_entry,
   input  wire logic             pop,
   output map_entry_type         head_entry,
   output queue_status_type      status
);

   map_entry_type            mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   assign head_entry       = mem_ff[rd_ptr_ff];
   assign status.full      = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign status.not_empty = count_ff != '0;
   assign status.count     = count_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/csm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module csm_back
   import csm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire map_entry_type        head_entry,
   input  wire queue_status_type     q_status,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [SAMPLE_W-1:0]       rsp_mapped,
   output logic [SAMPLE_W-1:0]       rsp_low,
   output logic [SAMPLE_W-1:0]       rsp_high
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_HOLD
   } state_type;

   state_type             state_ff;
   map_entry_type         job_ff;
   logic [SPAN_W-1:0]     rem_ff;
   logic [SAMPLE_W-1:0]   quo_ff;
   logic [STEP_CNT_W-1:0] step_ff;
   logic                  rsp_valid_ff;
   logic [SAMPLE_W-1:0]   rsp_mapped_ff, rsp_low_ff, rsp_high_ff;

   logic [SPAN_W:0]       rem_shift;
   logic [SPAN_W:0]       rem_diff;
   logic                  quo_bit;
   logic                  out_free;
   logic                  load_rsp;
   logic [SAMPLE_W-1:0]   result;

   assign q_pop     = (state_ff == ST_IDLE) && q_status.not_empty;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_rsp  = (state_ff == ST_HOLD) && out_free;

   // one restoring step of (offset * 256) / span
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_diff  = rem_shift - {1'b0, job_ff.span};
   assign quo_bit   = rem_shift >= {1'b0, job_ff.span};

   always_comb begin
      priority if (job_ff.pass) result = job_ff.sample;
      else if (job_ff.full_scale) result = SAMPLE_MAX;
      else                        result = quo_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (q_status.not_empty) begin
                  job_ff   <= head_entry;
                  rem_ff   <= head_entry.offset;
                  quo_ff   <= '0;
                  step_ff  <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff  <= quo_bit ? rem_diff[SPAN_W-1:0] : rem_shift[SPAN_W-1:0];
               quo_ff  <= {quo_ff[SAMPLE_W-2:0], quo_bit};
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_CNT_W'(DIV_STEPS - 1)) state_ff <= ST_HOLD;
            end
            ST_HOLD: begin
               if (out_free) begin
                  rsp_mapped_ff <= result;
                  rsp_low_ff    <= job_ff.low;
                  rsp_high_ff   <= job_ff.high;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_mapped = rsp_mapped_ff;
   assign rsp_low    = rsp_low_ff;
   assign rsp_high   = rsp_high_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/contrast_stretch_mapper_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// linear contrast stretch of 8-bit samples, used in two passes over a stream
// req channel: tuser carries the command (clear, measure, map), tdata the sample
// clear and measure update the running min/max in the cycle they are accepted
// and give no rsp transaction; command code 3 is dropped
// a map transaction gives one rsp transaction carrying the stretched sample
// and the bounds it was mapped with; with nothing measured the sample passes
// through unchanged and the bounds read 255 and 0
// a map runs from req acceptance to rsp tvalid through the queue, pick-up by the
// back end, 8 divider steps and the result load into the output register
// throughput: clear/measure one per cycle while req tready is high; maps are
// taken by the bit-serial divider one at a time, at one quotient bit a cycle
// a 4-entry queue sits between front and back end, so up to four maps can be
// taken ahead while the divider is busy or a result waits
// rsp stall: the result holds in the output register; the divider then
// waits, the queue fills and req tready drops when it is full
// reset clears the bounds to 255/0, empties the queue and drops rsp tvalid

module contrast_stretch_mapper_unit
   import csm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] sample
   input  wire logic [1:0]  req_tuser,   // [1:0] command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata    // [7:0] mapped_sample, [15:8] low_bound,
                                         // [23:16] high_bound
);

   logic                q_push;
   logic                q_pop;
   map_entry_type       q_push_entry;
   map_entry_type       q_head_entry;
   queue_status_type    q_status;
   logic [SAMPLE_W-1:0] rsp_mapped, rsp_low, rsp_high;

   // front end: bounds and classification of map jobs
   csm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_command (req_tuser),
      .req_sample  (req_tdata),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_entry     (q_push_entry)
   );

   // decoupling queue of map jobs
   csm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head_entry (q_head_entry),
      .status     (q_status)
   );

   // back end: serial divider and output register
   csm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (q_head_entry),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_mapped (rsp_mapped),
      .rsp_low    (rsp_low),
      .rsp_high   (rsp_high)
   );

   assign rsp_tdata = {rsp_high, rsp_low, rsp_mapped};

`ifndef SYNTHESIS
   // an accepted map is always held somewhere in the queue next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == CMD_MAP) |=> q_status.not_empty)
      else $error("map transaction lost on its way into the queue");

   // with a single measured level every sample maps to full scale
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[15:8] == rsp_tdata[23:16]) |-> rsp_tdata[7:0] == SAMPLE_MAX)
      else $error("degenerate range not mapped to full scale");

   // nothing is presented straight after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp tvalid high right after reset");
`endif

endmodule

`default_nettype wire

// ----- test/stretch_checker.sv -----
`timescale 1ns / 1ps

// watches both channels, tracks the running bounds and checks every map result
module stretch_checker
   import csm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,
   output int               mismatch_count,
   output int               maps_in_flight
);

   typedef struct packed {
      logic [SAMPLE_W-1:0] high;
      logic [SAMPLE_W-1:0] low;
      logic [SAMPLE_W-1:0] mapped;
   } stretch_result_t;

   logic [SAMPLE_W-1:0] run_min;
   logic [SAMPLE_W-1:0] run_max;
   stretch_result_t     pending_maps[$];

   function automatic logic [SAMPLE_W-1:0] stretch_sample(input logic [SAMPLE_W-1:0] x,
                                                          input logic [SAMPLE_W-1:0] lo,
                                                          input logic [SAMPLE_W-1:0] hi);
      int clamped;
      int quotient;
      if (lo > hi)
         return x;
      clamped = x;
      if (clamped < lo)
         clamped = lo;
      if (clamped > hi)
         clamped = hi;
      quotient = (256 * (clamped - lo + 1)) / (hi - lo + 1);
      return SAMPLE_W'(quotient - 1);
   endfunction

   assign maps_in_flight = pending_maps.size();

   always @(posedge clock) begin
      stretch_result_t want;
      stretch_result_t got;
      if (reset) begin
         run_min        <= SAMPLE_MAX;
         run_max        <= SAMPLE_MIN;
         mismatch_count <= 0;
         pending_maps.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               CMD_CLEAR: begin
                  run_min <= SAMPLE_MAX;
                  run_max <= SAMPLE_MIN;
               end
               CMD_MEASURE: begin
                  if (req_tdata < run_min)
                     run_min <= req_tdata;
                  if (req_tdata > run_max)
                     run_max <= req_tdata;
               end
               CMD_MAP: begin
                  want.mapped = stretch_sample(req_tdata, run_min, run_max);
                  want.low    = run_min;
                  want.high   = run_max;
                  pending_maps.push_back(want);
               end
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_maps.size() == 0) begin
               $error("unexpected rsp transaction: tdata %h", rsp_tdata);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = pending_maps.pop_front();
               if (got.mapped !== want.mapped)
                  $error("mapped_sample mismatch: expected %0d, actual %0d",
                         want.mapped, got.mapped);
               if (got.low !== want.low)
                  $error("low_bound mismatch: expected %0d, actual %0d", want.low, got.low);
               if (got.high !== want.high)
                  $error("high_bound mismatch: expected %0d, actual %0d",
                         want.high, got.high);
               if (got !== want)
                  mismatch_count <= mismatch_count + 1;
            end
         end
      end
   end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

// stimulus and verdict for the contrast stretch mapper; checking sits in stretch_checker
module testbench;
   import csm_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;   // dropped by the block
   localparam int TARGET_ITEMS = 700;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 30;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] sample
   logic [1:0]  req_tuser;    // [1:0] command
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;    // [7:0] mapped_sample, [15:8] low_bound, [23:16] high_bound

   int   mismatch_count;
   int   maps_in_flight;
   int   cycle_count;
   int   items_sent;          // clear/measure/map transactions, the unused code not counted
   logic no_idle;             // long stretch with no req gaps and rsp tready always high

   contrast_stretch_mapper_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   stretch_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .maps_in_flight (maps_in_flight)
   );

   initial begin
      clock = 1'b0;
   end

   always #1 clock = ~clock;

   // hard stop in case the block hangs or loses a result
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // result side back-pressure, about 14 stalls in a hundred outside the quiet stretch
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= no_idle || ($urandom_range(99) >= 14);
   end

   // one req transaction: random gaps first, then hold tvalid until accepted;
   // tready is sampled at the falling edge, clear of the rising-edge updates
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SAMPLE_W-1:0] sample);
      logic ready_seen;
      while (!no_idle && $urandom_range(99) < 14) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         req_tuser  <= 2'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tuser  <= cmd;
      do begin
         @(negedge clock);
         ready_seen = req_tready;
         @(posedge clock);
      end while (!ready_seen);
      if (cmd != CMD_UNUSED)
         items_sent++;
   endtask

   // well-formed pass: optional clear, measure a random range (or nothing), then map samples
   task automatic stretch_pass();
      int lo;
      int hi;
      int n_measure;
      int n_map;
      int pick;
      lo = $urandom_range(255);
      hi = $urandom_range(255);
      if (lo > hi) begin
         pick = lo;
         lo   = hi;
         hi   = pick;
      end
      pick = $urandom_range(9);
      if (pick == 0) begin
         lo = 0;
         hi = 255;
      end else if (pick == 1) begin
         hi = lo;                         // single-valued range, span of one
      end
      if ($urandom_range(9) < 7)
         send_item(CMD_CLEAR, 8'($urandom));
      n_measure = $urandom_range(12, 1);
      if ($urandom_range(19) == 0)
         n_measure = 0;                   // map with nothing measured
      if (n_measure > 0)
         send_item(CMD_MEASURE, 8'(lo));
      for (int i = 1; i < n_measure; i++)
         send_item(CMD_MEASURE, 8'($urandom_range(hi, lo)));
      if (n_measure > 1)
         send_item(CMD_MEASURE, 8'(hi));
      n_map = $urandom_range(10, 1);
      for (int i = 0; i < n_map; i++) begin
         pick = $urandom_range(3);
         if (pick == 0)
            send_item(CMD_MAP, 8'($urandom_range(hi, lo)));
         else if (pick == 1)
            send_item(CMD_MAP, ($urandom_range(1) == 1) ? 8'(lo) : 8'(hi));
         else
            send_item(CMD_MAP, 8'($urandom));
      end
   endtask

   initial begin
      int noise_len;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = CMD_CLEAR;
      no_idle     = 1'b0;
      items_sent  = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: nothing measured, so maps pass straight through
      send_item(CMD_MAP, 8'd0);
      send_item(CMD_MAP, 8'd255);
      send_item(CMD_UNUSED, 8'd255);
      send_item(CMD_MAP, 8'd128);
      // single value measured: span of one
      send_item(CMD_MEASURE, 8'd100);
      send_item(CMD_MAP, 8'd99);
      send_item(CMD_MAP, 8'd100);
      send_item(CMD_MAP, 8'd101);
      // widen the range, samples below, inside and above the bounds
      send_item(CMD_MEASURE, 8'd200);
      send_item(CMD_MAP, 8'd50);
      send_item(CMD_MAP, 8'd150);
      send_item(CMD_MAP, 8'd250);
      // full range
      send_item(CMD_MEASURE, 8'd0);
      send_item(CMD_MEASURE, 8'd255);
      send_item(CMD_MAP, 8'd0);
      send_item(CMD_MAP, 8'd255);
      send_item(CMD_MAP, 8'd127);
      // clear goes back to pass-through
      send_item(CMD_CLEAR, 8'd0);
      send_item(CMD_MAP, 8'd77);
      // top-end single value
      send_item(CMD_MEASURE, 8'd255);
      send_item(CMD_MAP, 8'd255);
      send_item(CMD_MAP, 8'd0);
      send_item(CMD_CLEAR, 8'd255);

      // random part: mostly well-formed passes, some noise
      while (items_sent < TARGET_ITEMS) begin
         no_idle <= (items_sent >= 250 && items_sent < 400);
         if ($urandom_range(99) < 80) begin
            stretch_pass();
         end else begin
            noise_len = $urandom_range(5, 1);
            for (int i = 0; i < noise_len; i++)
               send_item(2'($urandom_range(3)), 8'($urandom));
         end
      end
      req_tvalid <= 1'b0;
      no_idle    <= 1'b0;
      // let the checker log the last accepted transaction first
      @(posedge clock);

      while (maps_in_flight != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && maps_in_flight == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/csm_pkg.sv
hw/rtl/csm_front.sv
hw/rtl/csm_queue.sv
hw/rtl/csm_back.sv
hw/rtl/contrast_stretch_mapper_unit.sv
test/stretch_checker.sv
test/testbench.sv
